[rtl/esc_pkg.sv]
// shared constants, state encoding and calendar helpers for the epoch to calendar converter
`default_nettype none

package esc_pkg;

	localparam int SECONDS_WIDTH_DEF = 32;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	localparam int HOUR_BITS = 5;
	localparam int MIN_BITS  = 6;

	localparam logic [7:0] FIRST_YEAR_OFS = 8'd70;
	localparam logic [8:0] FIRST_MOD400   = 9'd370;
	localparam logic [6:0] FIRST_MOD100   = 7'd70;
	localparam logic [8:0] LAST_MOD400    = 9'd399;
	localparam logic [6:0] LAST_MOD100    = 7'd99;
	localparam logic [2:0] FIRST_WEEKDAY  = 3'd4;

	localparam logic [3:0] MONTH_JAN  = 4'd0;
	localparam logic [3:0] MONTH_FEB  = 4'd1;
	localparam logic [3:0] MONTH_APR  = 4'd3;
	localparam logic [3:0] MONTH_JUN  = 4'd5;
	localparam logic [3:0] MONTH_SEP  = 4'd8;
	localparam logic [3:0] MONTH_NOV  = 4'd10;
	localparam logic [3:0] LAST_MONTH = 4'd11;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DAY  = 6'b000010,
		ST_HOUR = 6'b000100,
		ST_MIN  = 6'b001000,
		ST_YEAR = 6'b010000,
		ST_MON  = 6'b100000
	} state_t;

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon) inside
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] mod7_5(input logic [4:0] x);
		logic [4:0] r;
		r = x;
		if (r >= 5'd28) r = r - 5'd28;
		if (r >= 5'd14) r = r - 5'd14;
		if (r >= 5'd7)  r = r - 5'd7;
		return r[2:0];
	endfunction

	function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 4'd7) s = s - 4'd7;
		return s[2:0];
	endfunction

endpackage

`default_nettype wire

[rtl/esc_subcmp.sv]
// shared subtract and compare unit used by every step of the converter
`default_nettype none

module esc_subcmp #(
	parameter int W = 32
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic [W:0] wide;

	always_comb begin
		wide = {1'b0, a} - {1'b0, b};
		diff = wide[W-1:0];
		ge   = ~wide[W];
	end

endmodule

`default_nettype wire

[rtl/epoch_seconds_to_calendar.sv]
// top level: seconds since 1970 to broken-down utc calendar time
//
// usage
//   pulse or hold start with epoch_seconds; the transfer happens at a rising edge
//   where start is high and busy is low. busy stays high while the item is worked.
//   done is high for exactly one cycle; all result ports are valid in that cycle
//   and may change while the next item is worked.
// sequence and throughput
//   one item at a time through a single subtract/compare unit:
//   SECONDS_WIDTH - 16 restoring steps split days from time of day,
//   5 steps give the hour, 6 the minute, then one step per elapsed year plus one,
//   then one step per elapsed month plus one.
//   busy falls with done, so a new start can be taken in the done cycle.
// reset
//   arst_n clears the sequencer and done; result ports hold no meaningful value
//   until the first done. the receiver cannot stall; done is not held.
`default_nettype none

module epoch_seconds_to_calendar #(
	parameter int SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [SECONDS_WIDTH-1:0] epoch_seconds,
	output logic                          busy,
	output logic                          done,
	output logic      [5:0]               second,
	output logic      [5:0]               minute,
	output logic      [4:0]               hour,
	output logic      [4:0]               day_of_month,
	output logic      [3:0]               month_index,
	output logic      [7:0]               years_since_1900,
	output logic      [8:0]               day_of_year,
	output logic      [2:0]               weekday
);

	localparam int DAYS_W = SECONDS_WIDTH - 16;
	localparam int CNT_W  = $clog2(DAYS_W);
	localparam logic [SECONDS_WIDTH-1:0] DAY_DVS =
		SECONDS_WIDTH'(esc_pkg::SECS_PER_DAY) << (DAYS_W - 1);
	localparam logic [SECONDS_WIDTH-1:0] HOUR_DVS =
		SECONDS_WIDTH'(esc_pkg::SECS_PER_HOUR) << (esc_pkg::HOUR_BITS - 1);
	localparam logic [SECONDS_WIDTH-1:0] MIN_DVS =
		SECONDS_WIDTH'(esc_pkg::SECS_PER_MIN) << (esc_pkg::MIN_BITS - 1);

	esc_pkg::state_t state_q;

	logic [SECONDS_WIDTH-1:0] acc_q;
	logic [SECONDS_WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DAYS_W-1:0]        days_q;
	logic [4:0]               hour_q;
	logic [5:0]               min_q;
	logic [5:0]               sec_q;
	logic [7:0]               year_q;
	logic [8:0]               m400_q;
	logic [6:0]               m100_q;
	logic [2:0]               wday_q;
	logic [8:0]               yday_q;
	logic                     leap_q;
	logic [3:0]               mon_q;
	logic [4:0]               dom_q;
	logic                     done_q;

	logic                     leap;
	logic [8:0]               ylen;
	logic [4:0]               mlen;
	logic [SECONDS_WIDTH-1:0] opnd;
	logic [SECONDS_WIDTH-1:0] diff;
	logic                     ge;

	always_comb begin
		leap = ((m400_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
		ylen = leap ? 9'd366 : 9'd365;
		mlen = esc_pkg::month_len(mon_q, leap_q);
		case (state_q)
			esc_pkg::ST_YEAR: opnd = SECONDS_WIDTH'(ylen);
			esc_pkg::ST_MON:  opnd = SECONDS_WIDTH'(mlen);
			default:          opnd = dvs_q;
		endcase
	end

	esc_subcmp #(
		.W(SECONDS_WIDTH)
	) u_subcmp (
		.a    (acc_q),
		.b    (opnd),
		.diff (diff),
		.ge   (ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esc_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				esc_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= esc_pkg::ST_DAY;
					end
				end
				esc_pkg::ST_DAY: begin
					if (cnt_q == '0) begin
						state_q <= esc_pkg::ST_HOUR;
					end
				end
				esc_pkg::ST_HOUR: begin
					if (cnt_q == '0) begin
						state_q <= esc_pkg::ST_MIN;
					end
				end
				esc_pkg::ST_MIN: begin
					if (cnt_q == '0) begin
						state_q <= esc_pkg::ST_YEAR;
					end
				end
				esc_pkg::ST_YEAR: begin
					if (!ge) begin
						state_q <= esc_pkg::ST_MON;
					end
				end
				esc_pkg::ST_MON: begin
					if (!((mon_q != esc_pkg::LAST_MONTH) && ge)) begin
						state_q <= esc_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= esc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			esc_pkg::ST_IDLE: begin
				if (start) begin
					acc_q <= epoch_seconds;
					dvs_q <= DAY_DVS;
					cnt_q <= CNT_W'(DAYS_W - 1);
				end
			end
			esc_pkg::ST_DAY: begin
				if (ge) acc_q <= diff;
				days_q <= {days_q[DAYS_W-2:0], ge};
				dvs_q  <= dvs_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					dvs_q <= HOUR_DVS;
					cnt_q <= CNT_W'(esc_pkg::HOUR_BITS - 1);
				end
			end
			esc_pkg::ST_HOUR: begin
				if (ge) acc_q <= diff;
				hour_q <= {hour_q[3:0], ge};
				dvs_q  <= dvs_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					dvs_q <= MIN_DVS;
					cnt_q <= CNT_W'(esc_pkg::MIN_BITS - 1);
				end
			end
			esc_pkg::ST_MIN: begin
				if (ge) acc_q <= diff;
				min_q <= {min_q[4:0], ge};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					sec_q  <= ge ? diff[5:0] : acc_q[5:0];
					acc_q  <= SECONDS_WIDTH'(days_q);
					year_q <= esc_pkg::FIRST_YEAR_OFS;
					m400_q <= esc_pkg::FIRST_MOD400;
					m100_q <= esc_pkg::FIRST_MOD100;
					wday_q <= esc_pkg::FIRST_WEEKDAY;
				end
			end
			esc_pkg::ST_YEAR: begin
				if (ge) begin
					acc_q  <= diff;
					year_q <= year_q + 1'b1;
					m400_q <= (m400_q == esc_pkg::LAST_MOD400) ? 9'd0 : m400_q + 1'b1;
					m100_q <= (m100_q == esc_pkg::LAST_MOD100) ? 7'd0 : m100_q + 1'b1;
					wday_q <= esc_pkg::add_mod7(wday_q, leap ? 3'd2 : 3'd1);
				end else begin
					yday_q <= acc_q[8:0];
					leap_q <= leap;
					mon_q  <= esc_pkg::MONTH_JAN;
				end
			end
			esc_pkg::ST_MON: begin
				if ((mon_q != esc_pkg::LAST_MONTH) && ge) begin
					acc_q  <= diff;
					mon_q  <= mon_q + 1'b1;
					wday_q <= esc_pkg::add_mod7(wday_q, esc_pkg::mod7_5(mlen));
				end else begin
					dom_q  <= acc_q[4:0] + 5'd1;
					wday_q <= esc_pkg::add_mod7(wday_q, esc_pkg::mod7_5(acc_q[4:0]));
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign busy             = (state_q != esc_pkg::ST_IDLE);
	assign done             = done_q;
	assign second           = sec_q;
	assign minute           = min_q;
	assign hour             = hour_q;
	assign day_of_month     = dom_q;
	assign month_index      = mon_q;
	assign years_since_1900 = year_q;
	assign day_of_year      = yday_q;
	assign weekday          = wday_q;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transfer did not start work");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((month_index <= esc_pkg::LAST_MONTH) && (day_of_month != 5'd0)
			&& (weekday != 3'd7) && (hour < 5'd24) && (minute < 6'd60)
			&& (second < 6'd60)))
		else $error("result field out of range");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_epoch_seconds_to_calendar.sv]
// testbench for the epoch seconds to calendar converter: self-checking against a predicted calendar
`timescale 1ns / 100ps

localparam int unsigned DAY_SECS      = 86400;
localparam int unsigned HOUR_SECS     = 3600;
localparam int unsigned MINUTE_SECS   = 60;
localparam int unsigned EPOCH_YEAR    = 1970;
localparam int unsigned CIVIL_BASE    = 1900;
localparam int unsigned EPOCH_WEEKDAY = 4;

typedef struct packed {
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [4:0] day_of_month;
	logic [3:0] month_index;
	logic [7:0] years_since_1900;
	logic [8:0] day_of_year;
	logic [2:0] weekday;
} calendar_t;

class calendar_scoreboard;
	calendar_t expected_dates[$];
	int unsigned failures;

	function new();
		failures = 0;
	endfunction

	function bit leap_year(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
	endfunction

	function calendar_t civil_time(logic [31:0] secs);
		calendar_t c;
		int unsigned days, sod, yr, ylen, rem, mon, mlen;
		int unsigned month_days[12];
		month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		days = secs / DAY_SECS;
		sod = secs % DAY_SECS;
		c.weekday = 3'((days + EPOCH_WEEKDAY) % 7);
		c.hour = 5'(sod / HOUR_SECS);
		c.minute = 6'((sod % HOUR_SECS) / MINUTE_SECS);
		c.second = 6'(sod % MINUTE_SECS);
		yr = EPOCH_YEAR;
		ylen = leap_year(yr) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = leap_year(yr) ? 366 : 365;
		end
		c.years_since_1900 = 8'(yr - CIVIL_BASE);
		c.day_of_year = 9'(days);
		rem = days;
		mon = 0;
		while (mon < 11) begin
			mlen = month_days[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
			if (rem < mlen)
				break;
			rem -= mlen;
			mon++;
		end
		c.month_index = 4'(mon);
		c.day_of_month = 5'(rem + 1);
		return c;
	endfunction

	function void note_transfer(logic [31:0] secs);
		expected_dates.push_back(civil_time(secs));
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(calendar_t got);
		calendar_t want;
		if (expected_dates.size() == 0) begin
			$error("result with no transfer pending");
			failures++;
			return;
		end
		want = expected_dates.pop_front();
		compare_field("second", want.second, got.second);
		compare_field("minute", want.minute, got.minute);
		compare_field("hour", want.hour, got.hour);
		compare_field("day_of_month", want.day_of_month, got.day_of_month);
		compare_field("month_index", want.month_index, got.month_index);
		compare_field("years_since_1900", want.years_since_1900, got.years_since_1900);
		compare_field("day_of_year", want.day_of_year, got.day_of_year);
		compare_field("weekday", want.weekday, got.weekday);
	endfunction

	function int unsigned outstanding();
		return expected_dates.size();
	endfunction
endclass

module tb_epoch_seconds_to_calendar;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic [31:0] epoch_seconds;
	logic        busy;
	logic        done;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [4:0]  day_of_month;
	logic [3:0]  month_index;
	logic [7:0]  years_since_1900;
	logic [8:0]  day_of_year;
	logic [2:0]  weekday;

	calendar_scoreboard board;

	logic [31:0] corner_seconds[21] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
		32'd5097599, 32'd5097600, 32'd31535999, 32'd31536000, 32'd68169600,
		32'd94694399, 32'd951782400, 32'd978307199, 32'd4107542399, 32'd4107542400,
		32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF
	};

	epoch_seconds_to_calendar dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.epoch_seconds    (epoch_seconds),
		.busy             (busy),
		.done             (done),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.weekday          (weekday)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_transfer(epoch_seconds);
			if (done)
				board.check_result(calendar_t'({second, minute, hour, day_of_month,
					month_index, years_since_1900, day_of_year, weekday}));
		end
	end

	task automatic send_seconds(input logic [31:0] secs);
		@(negedge clk);
		start <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			epoch_seconds <= $urandom;
		end
	endtask

	function automatic logic [31:0] pick_seconds();
		int unsigned day;
		day = $urandom_range(0, 49709);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(day * DAY_SECS + ($urandom_range(0, 1) ? DAY_SECS - 1 : 0));
			2: return $urandom_range(0, 4 * 366 * DAY_SECS);
			default: return 32'hFFFFFFFF - $urandom_range(0, 400 * DAY_SECS);
		endcase
	endfunction

	initial begin
		int unsigned guard;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		epoch_seconds = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (corner_seconds[i]) begin
			send_seconds(corner_seconds[i]);
			if ($urandom_range(0, 99) < 32)
				hold_off($urandom_range(1, 180));
		end

		for (int i = 0; i < 930; i++) begin
			send_seconds(pick_seconds());
			if (i == 600) begin
				hold_off(1);
				while (board.outstanding() != 0)
					@(posedge clk);
			end
			// no idling between items 300 and 499
			if (!(i >= 300 && i < 500) && $urandom_range(0, 99) < 32)
				hold_off($urandom_range(1, 180));
		end
		hold_off(1);

		guard = 0;
		while (board.outstanding() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);

		if (board.failures == 0 && board.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

[filelist.f]
rtl/esc_pkg.sv
rtl/esc_subcmp.sv
rtl/epoch_seconds_to_calendar.sv
tb/sv/tb_epoch_seconds_to_calendar.sv
